/* src/fwna_pkg.sv */
// fwna_pkg: shared types, constants and helpers for the number-to-ascii block
// used by fwna_ctrl, fwna_dp and fixed_width_number_to_ascii; no dependencies
`timescale 1ns / 1ps

package fwna_pkg;

  localparam int DefMaxDigits = 32;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_BIN  = 2'd3;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  localparam int DecDigits = 10;
  localparam int ConvSteps = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [5:0]  digit_count;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] character;
    logic [5:0] position;
    logic       last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic is_signed;
    logic count_zero;
    logic conv_done;
    logic k_zero;
    logic out_free;
  } dp_status_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + 7'(d);
    end else begin
      r = CH_A + 7'(d - 4'd10);
    end
    return r;
  endfunction

endpackage

/* src/fwna_ctrl.sv */
// fwna_ctrl: sequencer for the number-to-ascii block
// drives dp_cmd_t to fwna_dp and reads dp_status_t back; uses fwna_pkg
`timescale 1ns / 1ps

module fwna_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fwna_pkg::dp_status_t st_i,
  output fwna_pkg::dp_cmd_t    cmd_o
);
  import fwna_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (st_i.is_dec) state_d = ST_CONV;
        else if (st_i.count_zero) state_d = ST_IDLE;
        else state_d = ST_DIGITS;
      end
      ST_CONV: begin
        if (st_i.conv_done) begin
          priority if (st_i.is_signed) state_d = ST_SIGN;
          else if (st_i.count_zero) state_d = ST_IDLE;
          else state_d = ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (st_i.out_free) state_d = st_i.count_zero ? ST_IDLE : ST_DIGITS;
      end
      ST_DIGITS: begin
        if (st_i.out_free && st_i.k_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DISPATCH: ;
      ST_CONV:     cmd_o.conv_step = 1'b1;
      ST_SIGN:     cmd_o.emit_sign = st_i.out_free;
      ST_DIGITS:   cmd_o.emit_digit = st_i.out_free;
      default: ;
    endcase
  end

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again straight after a beat");

  a_conv_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && !st_i.conv_done) |=> state_q == ST_CONV)
    else $error("conversion left early");

  a_digits_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS && st_i.out_free) |-> cmd_o.emit_digit)
    else $error("free output slot not used");

endmodule

/* src/fwna_dp.sv */
// fwna_dp: operand registers, shift-add-3 bcd converter, digit select
// and output register; commanded by fwna_ctrl, uses fwna_pkg
`timescale 1ns / 1ps

module fwna_dp #(
  parameter int MAX_DIGITS = fwna_pkg::DefMaxDigits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fwna_pkg::in_beat_t   in_beat_i,
  input  fwna_pkg::dp_cmd_t    cmd_i,
  output fwna_pkg::dp_status_t st_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fwna_pkg::out_beat_t  out_beat_o
);
  import fwna_pkg::*;

  localparam int KW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [5:0] MaxCount = 6'(MAX_DIGITS);

  logic [1:0]            kind_q, kind_d;
  logic                  neg_q, neg_d;
  logic                  count_zero_q, count_zero_d;
  logic [31:0]           value_q, value_d;
  logic [DecDigits-1:0][3:0] bcd_q, bcd_d, adj;
  logic [4*DecDigits-1:0] adj_flat;
  logic [KW-1:0]         k_q, k_d;
  logic [5:0]            pos_q, pos_d;
  logic [4:0]            it_q, it_d;
  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_beat_q, out_beat_d;

  logic [5:0]            count_sat;
  logic [4:0]            k5;
  logic [7:0][3:0]       nib;
  logic [3:0]            digit;

  assign count_sat = (in_beat_i.digit_count > MaxCount) ? MaxCount : in_beat_i.digit_count;
  assign k5        = 5'(k_q);
  assign nib       = value_q;
  assign adj_flat  = adj;

  // add 3 to each bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_UDEC, KIND_SDEC: digit = (k5 < 5'(DecDigits)) ? bcd_q[k5[3:0]] : 4'd0;
      KIND_HEX:             digit = (k5 < 5'd8) ? nib[k5[2:0]] : 4'd0;
      KIND_BIN:             digit = {3'b000, value_q[k5]};
      default:              digit = 4'd0;
    endcase
  end

  always_comb begin
    kind_d       = kind_q;
    neg_d        = neg_q;
    count_zero_d = count_zero_q;
    value_d      = value_q;
    bcd_d        = bcd_q;
    k_d          = k_q;
    pos_d        = pos_q;
    it_d         = it_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_beat_d   = out_beat_q;
    if (cmd_i.load) begin
      kind_d       = in_beat_i.kind;
      neg_d        = (in_beat_i.kind == KIND_SDEC) && in_beat_i.value[31];
      value_d      = neg_d ? 32'(32'd0 - in_beat_i.value) : in_beat_i.value;
      count_zero_d = (count_sat == 6'd0);
      k_d          = KW'(count_sat - 6'd1);
      pos_d        = 6'd0;
      it_d         = 5'd0;
      bcd_d        = '0;
    end
    if (cmd_i.conv_step) begin
      bcd_d   = {adj_flat[4*DecDigits-2:0], value_q[31]};
      value_d = {value_q[30:0], 1'b0};
      it_d    = it_q + 5'd1;
    end
    if (cmd_i.emit_sign) begin
      out_valid_d          = 1'b1;
      out_beat_d.character = neg_q ? CH_MINUS : CH_PLUS;
      out_beat_d.position  = pos_q;
      out_beat_d.last      = count_zero_q;
      pos_d                = pos_q + 6'd1;
    end
    if (cmd_i.emit_digit) begin
      out_valid_d          = 1'b1;
      out_beat_d.character = digit_to_ascii(digit);
      out_beat_d.position  = pos_q;
      out_beat_d.last      = (k_q == '0);
      pos_d                = pos_q + 6'd1;
      k_d                  = k_q - KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    neg_q        <= neg_d;
    count_zero_q <= count_zero_d;
    value_q      <= value_d;
    bcd_q        <= bcd_d;
    k_q          <= k_d;
    pos_q        <= pos_d;
    it_q         <= it_d;
    out_beat_q   <= out_beat_d;
  end

  assign st_o.is_dec     = (kind_q == KIND_UDEC) || (kind_q == KIND_SDEC);
  assign st_o.is_signed  = (kind_q == KIND_SDEC);
  assign st_o.count_zero = count_zero_q;
  assign st_o.conv_done  = (it_q == 5'(ConvSteps - 1));
  assign st_o.k_zero     = (k_q == '0);
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sign || cmd_i.emit_digit) |-> (!out_valid_q || !out_stall_i))
    else $error("beat overwritten while stalled");

  a_conv_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.conv_step |-> (kind_q == KIND_UDEC || kind_q == KIND_SDEC))
    else $error("bcd conversion on a non-decimal format");

  a_sign_signed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_sign |-> (kind_q == KIND_SDEC && !cmd_i.emit_digit))
    else $error("sign outside signed decimal");

endmodule

/* src/fixed_width_number_to_ascii.sv */
// fixed_width_number_to_ascii: number to fixed-width ascii digits
// input beat: kind (unsigned/signed decimal, hex, binary), 32-bit value and
// digit count; output beats: one character each, most significant first,
// with its position and a last flag on the final character.
// both channels use valid/stall; a beat moves when valid is high and stall low.
// a count above MAX_DIGITS is clipped; count zero gives nothing, or just the
// sign in signed decimal. signed decimal leads with '+' or '-'.
// timing: the input is taken in the idle state and decoded in the dispatch state;
// decimal then runs a shift-add-3 bcd conversion over all 32 value bits, one value bit per cycle.
// characters leave at one per cycle from the output register while the
// receiver does not stall; hex and binary skip the conversion, and signed
// decimal sends its sign character before the digits.
// a receiver stall holds the output beat and pauses emission; a new input is
// taken as soon as the last character sits in the output register.
// reset clears the sequencer and the output valid; no clearing pass.
`timescale 1ns / 1ps

module fixed_width_number_to_ascii #(
  parameter int MAX_DIGITS = fwna_pkg::DefMaxDigits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fwna_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fwna_pkg::out_beat_t out_beat_o
);
  import fwna_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  fwna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fwna_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

/* tb/fixed_width_number_to_ascii_tb.sv */
`timescale 1ns / 1ps
// fixed_width_number_to_ascii_tb: self-checking bench for the number-to-ascii block
// a scoreboard class predicts every character beat; needs fwna_pkg and the block itself

module fixed_width_number_to_ascii_tb;
  import fwna_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned RandomNumbers = 170;
  localparam int unsigned QuietNumbers  = 40;
  localparam int unsigned PressureAt    = 80;
  localparam int unsigned DrainAt       = 110;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned DrainCycles   = 100;

  class char_scoreboard;
    out_beat_t   expected_q[$];
    int unsigned mismatches;
    int unsigned numbers_noted;
    int unsigned chars_checked;

    // digit of weight radix^k, zero once the weight leaves 32 bits
    function logic [3:0] digit_at_weight(logic [31:0] v, int unsigned radix, int unsigned k);
      longint unsigned w;
      logic [3:0]      d;
      w = 1;
      d = 4'(64'(v) % radix);
      repeat (k) begin
        w = w * radix;
        d = 4'((64'(v) / w) % radix);
        if (w > 64'hFFFF_FFFF) begin
          d = 4'd0;
          break;
        end
      end
      return d;
    endfunction

    function void note_number(in_beat_t b);
      logic [31:0] mag;
      logic [3:0]  d;
      int unsigned count;
      int unsigned radix;
      int unsigned pos;
      int unsigned i;
      out_beat_t   e;
      numbers_noted++;
      count = (b.digit_count > DefMaxDigits) ? DefMaxDigits : b.digit_count;
      case (b.kind)
        KIND_HEX: radix = 16;
        KIND_BIN: radix = 2;
        default:  radix = 10;
      endcase
      mag = b.value;
      pos = 0;
      if (b.kind == KIND_SDEC) begin
        e.character = b.value[31] ? CH_MINUS : CH_PLUS;
        e.position  = '0;
        e.last      = (count == 0);
        expected_q.push_back(e);
        if (b.value[31]) mag = 32'd0 - b.value;
        pos = 1;
      end
      for (i = 0; i < count; i++) begin
        d = digit_at_weight(mag, radix, count - 1 - i);
        e.character = (d < 4'd10) ? CH_ZERO + 7'(d) : CH_A + 7'(d - 4'd10);
        e.position  = 6'(pos + i);
        e.last      = (i + 1 == count);
        expected_q.push_back(e);
      end
    endfunction

    function void check_char(out_beat_t got);
      out_beat_t e;
      chars_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected character beat: character 'h%0h position %0d last %0b",
               got.character, got.position, got.last);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (got.character !== e.character) begin
          $error("character: expected 'h%0h, actual 'h%0h", e.character, got.character);
          mismatches++;
        end
        if (got.position !== e.position) begin
          $error("position: expected %0d, actual %0d", e.position, got.position);
          mismatches++;
        end
        if (got.last !== e.last) begin
          $error("last: expected %0b, actual %0b", e.last, got.last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  bit          quiet;
  bit          hold_req;
  int unsigned cycle_cnt;
  char_scoreboard sb;

  fixed_width_number_to_ascii i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_char(out_beat);
      if (in_valid && !in_stall) sb.note_number(in_beat);
    end
  end

  // receiver: random stall bursts, a long hold on request, none when quiet
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    logic        nxt;
    stall_left = 0;
    free_left  = 0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left != 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (quiet) begin
        nxt = 1'b0;
      end else if (free_left != 0) begin
        free_left--;
        nxt = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        nxt = 1'b1;
      end else begin
        free_left = $urandom_range(1, 40);
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("** fixed_width_number_to_ascii: FAILED **");
    $finish;
  end

  task automatic send_number(input logic [1:0] kind, input logic [31:0] value,
                             input logic [5:0] count, input bit may_idle);
    in_beat_t    b;
    int unsigned gap;
    b.kind        = kind;
    b.value       = value;
    b.digit_count = count;
    gap = 0;
    if (may_idle && !quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, 999);
      1:       v = 32'd0 - $urandom_range(0, 999);
      2:       v = 32'h1 << $urandom_range(0, 31);
      3:       v = (32'h1 << $urandom_range(0, 31)) - 32'h1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_count();
    logic [5:0] c;
    case ($urandom_range(0, 9))
      0:       c = 6'd0;
      1:       c = 6'($urandom_range(33, 63));
      2:       c = 6'd32;
      3:       c = 6'($urandom_range(13, 31));
      default: c = 6'($urandom_range(1, 12));
    endcase
    return c;
  endfunction

  initial begin
    int unsigned n;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_number(KIND_UDEC, 32'hFFFF_FFFF, 6'd10, 1'b1);
    send_number(KIND_UDEC, 32'hFFFF_FFFF, 6'd12, 1'b1);
    send_number(KIND_UDEC, 32'd0,         6'd1,  1'b1);
    send_number(KIND_UDEC, 32'd123456789, 6'd3,  1'b1);
    send_number(KIND_UDEC, 32'd42,        6'd0,  1'b1);
    send_number(KIND_UDEC, 32'h1234_5678, 6'd33, 1'b1);
    send_number(KIND_UDEC, 32'd0,         6'd63, 1'b1);
    send_number(KIND_SDEC, 32'h8000_0000, 6'd10, 1'b1);
    send_number(KIND_SDEC, 32'h7FFF_FFFF, 6'd10, 1'b1);
    send_number(KIND_SDEC, 32'hFFFF_FFFF, 6'd1,  1'b1);
    send_number(KIND_SDEC, 32'd0,         6'd0,  1'b1);
    send_number(KIND_SDEC, 32'h8000_0001, 6'd0,  1'b1);
    send_number(KIND_SDEC, 32'd5,         6'd63, 1'b1);
    send_number(KIND_HEX,  32'hDEAD_BEEF, 6'd8,  1'b1);
    send_number(KIND_HEX,  32'hABCD_EF01, 6'd10, 1'b1);
    send_number(KIND_HEX,  32'd0,         6'd0,  1'b1);
    send_number(KIND_HEX,  32'h0000_000F, 6'd1,  1'b1);
    send_number(KIND_HEX,  32'hFFFF_FFFF, 6'd40, 1'b1);
    send_number(KIND_BIN,  32'hAAAA_AAAA, 6'd32, 1'b1);
    send_number(KIND_BIN,  32'h5555_5555, 6'd32, 1'b1);
    send_number(KIND_BIN,  32'd1,         6'd40, 1'b1);
    send_number(KIND_BIN,  32'd0,         6'd0,  1'b1);

    for (n = 0; n < RandomNumbers; n++) begin
      quiet = (n >= RandomNumbers - QuietNumbers);
      if (n == PressureAt) begin
        // receiver holds off while numbers keep coming back to back
        hold_req = 1'b1;
        repeat (8) send_number(2'($urandom_range(0, 3)), $urandom(),
                               6'($urandom_range(2, 8)), 1'b0);
      end
      if (n == DrainAt) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_number(2'($urandom_range(0, 3)), pick_value(), pick_count(), 1'b1);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d numbers in all four formats, counts 0 to 63, and checked %0d characters",
             sb.numbers_noted, sb.chars_checked);
    $display("with random stalls on both sides, a long output hold and a full drain pause");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** fixed_width_number_to_ascii: PASSED **");
    end else begin
      $display("** fixed_width_number_to_ascii: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/fwna_pkg.sv
src/fwna_ctrl.sv
src/fwna_dp.sv
src/fixed_width_number_to_ascii.sv
tb/fixed_width_number_to_ascii_tb.sv
